// ===== hw/rtl/ftdv_pkg.sv =====
// ----------------------------------------------------------------------------
// ftdv_pkg
// Shared constants, types and controller/datapath command structs for the
// corner dedup and fan triangulation block.
// ----------------------------------------------------------------------------
package ftdv_pkg;

  localparam int TableDepth = 1024;
  localparam int KeyBits    = 24;
  localparam int InBits     = 24;
  localparam int OutIdxBits = 10;
  localparam int AddrBits   = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CountBits  = $clog2(TableDepth + 1);
  localparam int EntryBits  = 3 * KeyBits;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_INSERT,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item
    logic scan_start;  // issue first read, point scan pointer past entry 0
    logic scan_next;   // advance scan pointer
    logic compare;     // rdata holds a live entry, latch a hit
    logic finish;    // resolve lookup, update fan, load result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;  // no more entries to compare
    logic hit;        // entry read now matches key
  } stat_t;

  localparam logic [1:0] SeenNone = 2'd0;
  localparam logic [1:0] SeenOne  = 2'd1;
  localparam logic [1:0] SeenTwo  = 2'd2;
  localparam logic [1:0] SeenMany = 2'd3;

endpackage

// ===== hw/rtl/ftdv_ram.sv =====
// ----------------------------------------------------------------------------
// ftdv_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ftdv_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ftdv_ctrl.sv =====
// ----------------------------------------------------------------------------
// ftdv_ctrl
// Sequencer: accepts a corner, walks the table until hit or end, then
// resolves and presents the result.
// ----------------------------------------------------------------------------
module ftdv_ctrl
  import ftdv_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;
  logic   res_valid, res_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_READ;
      ST_READ:   state_next = stat.scan_done ? ST_INSERT : ST_CMP;
      ST_CMP: begin
        if (stat.hit) state_next = ST_OUT;
        else if (stat.scan_done) state_next = ST_INSERT;
      end
      ST_INSERT: state_next = ST_OUT;
      ST_OUT:    if (!res_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    res_valid_next = res_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_READ: cmd.scan_start = 1'b1;
      ST_CMP: begin
        cmd.compare   = 1'b1;
        cmd.scan_next = !stat.hit && !stat.scan_done;
      end
      ST_INSERT: ;
      ST_OUT: begin
        if (!res_valid || out_ready) begin
          cmd.finish     = 1'b1;
          res_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = res_valid;

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.scan_start, cmd.scan_next, cmd.finish}))
    else $error("controller issued overlapping commands");
  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> res_valid)
    else $error("finished result not presented");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_READ)
    else $error("load did not start a lookup");

endmodule

// ===== hw/rtl/ftdv_dp.sv =====
// ----------------------------------------------------------------------------
// ftdv_dp
// Datapath: input capture, key RAM and scan pointer, fan state and the
// output register.
// ----------------------------------------------------------------------------
module ftdv_dp
  import ftdv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic [InBits-1:0]     vertex_index,
  input  logic [InBits-1:0]     texcoord_index,
  input  logic [InBits-1:0]     normal_index,
  input  logic                  face_start,
  input  logic                  face_end,
  input  logic                  group_start,
  output logic [OutIdxBits-1:0] assigned_index,
  output logic                  is_new,
  output logic                  tri_valid,
  output logic [OutIdxBits-1:0] tri_head,
  output logic [OutIdxBits-1:0] tri_prev,
  output logic [OutIdxBits-1:0] tri_curr,
  output logic                  short_face,
  output logic                  table_full
);

  logic [EntryBits-1:0] key;
  logic                 fs, fe;
  logic [CountBits-1:0] entry_count;
  logic [CountBits-1:0] ptr;      // next entry to read
  logic [AddrBits-1:0]  cmp_addr; // entry whose data is on rdata
  logic [EntryBits-1:0] rdata;
  logic                 hit_q;
  logic [AddrBits-1:0]  hit_addr;
  logic [AddrBits-1:0]  head_corner, previous_corner;
  logic [1:0]           corners_seen;
  logic                 we;
  logic [AddrBits-1:0]  idx;
  logic                 full;

  // pointer reaching count means no entry left after the one on rdata; scan start checks for an empty table
  assign stat.hit       = (rdata == key);
  assign stat.scan_done = cmd.scan_start ? (entry_count == '0)
                                         : (ptr >= entry_count);

  assign full = !hit_q && (entry_count == CountBits'(TableDepth));
  assign idx  = hit_q ? hit_addr : (full ? '0 : entry_count[AddrBits-1:0]);
  assign we   = cmd.finish && !hit_q && !full;

  ftdv_ram #(.Width(EntryBits), .Depth(TableDepth)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(entry_count[AddrBits-1:0]),
    .wdata(key),
    .raddr(ptr[AddrBits-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count     <= '0;
      head_corner     <= '0;
      previous_corner <= '0;
      corners_seen    <= SeenNone;
      ptr             <= '0;
      hit_q           <= 1'b0;
    end else begin
      if (cmd.load) begin
        key <= {vertex_index[KeyBits-1:0], texcoord_index[KeyBits-1:0],
                normal_index[KeyBits-1:0]};
        fs  <= face_start;
        fe  <= face_end;
        hit_q <= 1'b0;
        ptr <= '0;
        if (group_start) entry_count <= '0;
      end
      if (cmd.scan_start) begin
        ptr      <= CountBits'(1);
        cmp_addr <= '0;
      end
      if (cmd.scan_next) begin
        ptr      <= ptr + 1'b1;
        cmp_addr <= ptr[AddrBits-1:0];
      end
      if (cmd.compare && stat.hit) begin
        hit_q    <= 1'b1;
        hit_addr <= cmp_addr;
      end
      if (cmd.finish) begin
        if (we) entry_count <= entry_count + 1'b1;
        if (fs || corners_seen == SeenNone) begin
          head_corner     <= idx;
          previous_corner <= idx;
          corners_seen    <= fe ? SeenNone : SeenOne;
          tri_valid       <= 1'b0;
          tri_head        <= '0;
          tri_prev        <= '0;
          tri_curr        <= '0;
          short_face      <= fe;
        end else if (corners_seen == SeenOne) begin
          previous_corner <= idx;
          corners_seen    <= fe ? SeenNone : SeenTwo;
          tri_valid       <= 1'b0;
          tri_head        <= '0;
          tri_prev        <= '0;
          tri_curr        <= '0;
          short_face      <= fe;
        end else begin
          tri_valid       <= 1'b1;
          tri_head        <= OutIdxBits'(head_corner);
          tri_prev        <= OutIdxBits'(previous_corner);
          tri_curr        <= OutIdxBits'(idx);
          previous_corner <= idx;
          corners_seen    <= fe ? SeenNone : SeenMany;
          short_face      <= 1'b0;
        end
        assigned_index <= OutIdxBits'(idx);
        is_new         <= we;
        table_full     <= full;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CountBits'(TableDepth))
    else $error("entry count beyond table depth");
  a_new_full: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> !(is_new && table_full))
    else $error("corner both inserted and rejected");
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    we |=> entry_count == $past(entry_count) + 1'b1)
    else $error("insert did not advance count");

endmodule

// ===== hw/rtl/fan_triangulate_dedup_vertices_top.sv =====
// ----------------------------------------------------------------------------
// fan_triangulate_dedup_vertices_top
// Corner dedup against a per-group table, plus triangle fan generation.
// ----------------------------------------------------------------------------
// One corner is processed at a time. The search reads the key RAM one entry
// per cycle through its single read port and stops at a hit. The result sits
// in an output register; the next corner is taken at once and searched while
// that result waits, and its own result is loaded only once the previous one
// is transferred or being transferred. No clearing pass is needed after reset;
// group_start empties the table at once.
module fan_triangulate_dedup_vertices_top
  import ftdv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [InBits-1:0]     vertex_index,
  input  logic [InBits-1:0]     texcoord_index,
  input  logic [InBits-1:0]     normal_index,
  input  logic                  face_start,
  input  logic                  face_end,
  input  logic                  group_start,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OutIdxBits-1:0] assigned_index,
  output logic                  is_new,
  output logic                  tri_valid,
  output logic [OutIdxBits-1:0] tri_head,
  output logic [OutIdxBits-1:0] tri_prev,
  output logic [OutIdxBits-1:0] tri_curr,
  output logic                  short_face,
  output logic                  table_full
);

  cmd_t  cmd;
  stat_t stat;

  ftdv_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  ftdv_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .vertex_index(vertex_index), .texcoord_index(texcoord_index),
    .normal_index(normal_index), .face_start(face_start),
    .face_end(face_end), .group_start(group_start),
    .assigned_index(assigned_index), .is_new(is_new), .tri_valid(tri_valid),
    .tri_head(tri_head), .tri_prev(tri_prev), .tri_curr(tri_curr),
    .short_face(short_face), .table_full(table_full)
  );

endmodule

// ===== bench/tb_fan_triangulate_dedup_vertices_top.sv =====
// ----------------------------------------------------------------------------
// tb_fan_triangulate_dedup_vertices_top
// Checks corner dedup and fan triangulation against a behavioral predictor:
// directed framing cases, a full table, then random faces and groups, with
// random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_fan_triangulate_dedup_vertices_top;
  import ftdv_pkg::*;

  typedef struct packed {
    logic [OutIdxBits-1:0] assigned_index;
    logic                  is_new;
    logic                  tri_valid;
    logic [OutIdxBits-1:0] tri_head;
    logic [OutIdxBits-1:0] tri_prev;
    logic [OutIdxBits-1:0] tri_curr;
    logic                  short_face;
    logic                  table_full;
  } corner_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [InBits-1:0]     vertex_index = '0;
  logic [InBits-1:0]     texcoord_index = '0;
  logic [InBits-1:0]     normal_index = '0;
  logic                  face_start = 1'b0;
  logic                  face_end = 1'b0;
  logic                  group_start = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OutIdxBits-1:0] assigned_index;
  logic                  is_new;
  logic                  tri_valid;
  logic [OutIdxBits-1:0] tri_head;
  logic [OutIdxBits-1:0] tri_prev;
  logic [OutIdxBits-1:0] tri_curr;
  logic                  short_face;
  logic                  table_full;

  fan_triangulate_dedup_vertices_top DUT (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [KeyBits-1:0]   pos_keys [TableDepth];
  logic [KeyBits-1:0]   tex_keys [TableDepth];
  logic [KeyBits-1:0]   nrm_keys [TableDepth];
  int                   table_count;
  logic [OutIdxBits-1:0] fan_head;
  logic [OutIdxBits-1:0] fan_prev;
  logic [1:0]           fan_seen;

  // expected results in transfer order
  corner_result_t expected_fifo [16];
  logic [3:0]     exp_wr = '0;
  logic [3:0]     exp_rd = '0;
  int  error_count;
  bit  quiet;

  function automatic corner_result_t predict_corner(
      logic [KeyBits-1:0] p, logic [KeyBits-1:0] t, logic [KeyBits-1:0] n,
      logic fs, logic fe, logic gs);
    corner_result_t r;
    int idx;
    bit found;
    r = '0;
    idx = 0;
    found = 0;
    if (gs) table_count = 0;
    for (int i = 0; i < table_count; i++) begin
      if (!found && pos_keys[i] == p && tex_keys[i] == t && nrm_keys[i] == n) begin
        idx = i;
        found = 1;
      end
    end
    if (!found) begin
      if (table_count < TableDepth) begin
        pos_keys[table_count] = p;
        tex_keys[table_count] = t;
        nrm_keys[table_count] = n;
        idx = table_count;
        table_count++;
        r.is_new = 1'b1;
      end else begin
        idx = 0;
        r.table_full = 1'b1;
      end
    end
    r.assigned_index = idx[OutIdxBits-1:0];
    if (fs || fan_seen == SeenNone) begin
      fan_head = idx[OutIdxBits-1:0];
      fan_prev = idx[OutIdxBits-1:0];
      fan_seen = SeenOne;
    end else if (fan_seen == SeenOne) begin
      fan_prev = idx[OutIdxBits-1:0];
      fan_seen = SeenTwo;
    end else begin
      r.tri_valid = 1'b1;
      r.tri_head = fan_head;
      r.tri_prev = fan_prev;
      r.tri_curr = idx[OutIdxBits-1:0];
      fan_prev = idx[OutIdxBits-1:0];
      fan_seen = SeenMany;
    end
    if (fe) begin
      r.short_face = (fan_seen != SeenMany);
      fan_seen = SeenNone;
    end
    return r;
  endfunction

  task automatic send_corner(logic [InBits-1:0] p, logic [InBits-1:0] t,
                             logic [InBits-1:0] n, logic fs, logic fe, logic gs);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    vertex_index   <= p;
    texcoord_index <= t;
    normal_index   <= n;
    face_start     <= fs;
    face_end       <= fe;
    group_start    <= gs;
    do @(posedge clk); while (!in_ready);
    expected_fifo[exp_wr] = predict_corner(p, t, n, fs, fe, gs);
    exp_wr = exp_wr + 4'd1;
  endtask

  // result checker and receiver stalls
  int stall_left;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        corner_result_t got, want;
        got = '{assigned_index, is_new, tri_valid, tri_head, tri_prev, tri_curr,
                short_face, table_full};
        if (exp_wr == exp_rd) begin
          $display("%0t: unexpected result, actual %p", $time, got);
          error_count++;
        end else begin
          want = expected_fifo[exp_rd];
          exp_rd = exp_rd + 4'd1;
          if (got !== want) begin
            $display("%0t: mismatch, expected %p actual %p", $time, want, got);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    // one-corner face, two-corner face, extremes of keys
    send_corner('0, '0, '0, 1'b1, 1'b1, 1'b1);
    send_corner('1, '1, '1, 1'b1, 1'b0, 1'b0);
    send_corner('0, '0, '0, 1'b0, 1'b1, 1'b0);
    // quad with a repeated corner
    send_corner(24'h000001, 24'h000002, 24'h000003, 1'b1, 1'b0, 1'b0);
    send_corner('1, '1, '1, 1'b0, 1'b0, 1'b0);
    send_corner(24'h000004, 24'h0, 24'h0, 1'b0, 1'b0, 1'b0);
    send_corner(24'h000001, 24'h000002, 24'h000003, 1'b0, 1'b1, 1'b0);
    // keys differing in one field only
    send_corner(24'h000001, 24'h000002, 24'h000000, 1'b1, 1'b0, 1'b0);
    send_corner(24'h000001, 24'h000000, 24'h000003, 1'b0, 1'b0, 1'b0);
    // face start inside an open face abandons it
    send_corner(24'h800000, 24'h000001, 24'h000001, 1'b1, 1'b0, 1'b0);
    send_corner(24'h800000, 24'h800000, 24'h800000, 1'b0, 1'b0, 1'b0);
    send_corner(24'h000005, 24'h000005, 24'h000005, 1'b0, 1'b1, 1'b0);
    // no face open and no face start
    send_corner(24'h000006, 24'h000006, 24'h000006, 1'b0, 1'b0, 1'b0);
    send_corner(24'h000007, 24'h000007, 24'h000007, 1'b0, 1'b0, 1'b0);
    // face straddling a group start
    send_corner(24'h000008, 24'h000008, 24'h000008, 1'b0, 1'b0, 1'b1);
    send_corner('1, '1, '1, 1'b0, 1'b1, 1'b0);
    send_corner('1, '1, '1, 1'b0, 1'b1, 1'b1);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < TableDepth; i++)
      send_corner(InBits'(i), InBits'(i + 1), InBits'(i + 2), (i % 3) == 0,
                  (i % 3) == 2, i == 0);
    send_corner(24'hABCDEF, 24'h1, 24'h2, 1'b1, 1'b0, 1'b0);
    send_corner(24'hFEDCBA, 24'h3, 24'h4, 1'b0, 1'b0, 1'b0);
    send_corner(InBits'(TableDepth - 1), InBits'(TableDepth), InBits'(TableDepth + 1),
                1'b0, 1'b0, 1'b0);
    send_corner(24'h0, 24'h1, 24'h2, 1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_random();
    logic [InBits-1:0] p, t, n;
    int corners;
    for (int item = 0; item < 100; ) begin
      if (item > 85) quiet = 1;
      corners = $urandom_range(1, 7);
      for (int c = 0; c < corners; c++) begin
        if ($urandom_range(0, 1)) begin
          p = InBits'($urandom_range(0, 15));
          t = InBits'($urandom_range(0, 3));
          n = InBits'($urandom_range(0, 3));
        end else begin
          p = InBits'($urandom);
          t = InBits'($urandom);
          n = InBits'($urandom);
        end
        if ($urandom_range(0, 9) == 0)
          // noise: arbitrary framing
          send_corner(p, t, n, 1'($urandom), 1'($urandom),
                      $urandom_range(0, 7) == 0);
        else
          send_corner(p, t, n, c == 0, c == corners - 1,
                      c == 0 && $urandom_range(0, 5) == 0);
        item++;
      end
    end
  endtask

  initial begin
    error_count = 0;
    quiet = 0;
    stall_left = 0;
    table_count = 0;
    fan_head = '0;
    fan_prev = '0;
    fan_seen = SeenNone;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_table_full();
    test_random();
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (TableDepth + 20) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #100000000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ftdv_pkg.sv
hw/rtl/ftdv_ram.sv
hw/rtl/ftdv_ctrl.sv
hw/rtl/ftdv_dp.sv
hw/rtl/fan_triangulate_dedup_vertices_top.sv
bench/tb_fan_triangulate_dedup_vertices_top.sv
